// File: hdl/srf_pkg.sv
// Package for the saturation run flattener: payload structs, configuration
// struct, register indexes and reset values. No dependencies.
package srf_pkg;

    localparam int MAX_FRAME_DEF = 65536;
    localparam int IDX_W         = 16;
    localparam int SAMPLE_W      = 32;
    localparam int GAP_W         = 16;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 32;

    localparam logic signed [SAMPLE_W-1:0] SAT_THRESHOLD_RST = 32'sh7FFF_FFFF;
    localparam logic [GAP_W-1:0]           GAP_LENGTH_RST    = 16'd4;
    localparam logic [IDX_W-1:0]           START_LIMIT_RST   = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_SAT_THRESHOLD = 2'd0,
        REG_GAP_LENGTH    = 2'd1,
        REG_START_LIMIT   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]           run_start;
        logic [IDX_W-1:0]           run_end;
        logic signed [SAMPLE_W-1:0] peak;
    } t_out;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sat_threshold;
        logic [GAP_W-1:0]           gap_length;
        logic [IDX_W-1:0]           start_limit;
    } t_cfg;

endpackage

// File: hdl/srf_regs.sv
// Configuration registers of the saturation run flattener behind an
// APB-style port. Depends on srf_pkg.
module srf_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [srf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [srf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output srf_pkg::t_cfg                   o_cfg
);

    srf_pkg::t_cfg    r_cfg;
    srf_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign reg_idx = srf_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sat_threshold <= srf_pkg::SAT_THRESHOLD_RST;
            r_cfg.gap_length    <= srf_pkg::GAP_LENGTH_RST;
            r_cfg.start_limit   <= srf_pkg::START_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                srf_pkg::REG_SAT_THRESHOLD: r_cfg.sat_threshold <= $signed(pwdata);
                srf_pkg::REG_GAP_LENGTH:    r_cfg.gap_length    <= pwdata[15:0];
                srf_pkg::REG_START_LIMIT:   r_cfg.start_limit   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            srf_pkg::REG_SAT_THRESHOLD: prdata = r_cfg.sat_threshold;
            srf_pkg::REG_GAP_LENGTH:    prdata = {16'd0, r_cfg.gap_length};
            srf_pkg::REG_START_LIMIT:   prdata = {16'd0, r_cfg.start_limit};
            default:                    prdata = '0;
        endcase
    end

endmodule

// File: hdl/srf_core.sv
// Run tracking state of the saturation run flattener and the single-pass
// logic that updates it for one sample. Depends on srf_pkg.
module srf_core #(
    parameter int MAX_FRAME = srf_pkg::MAX_FRAME_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  srf_pkg::t_in  i_item,
    input  srf_pkg::t_cfg i_cfg,
    output logic          o_res_valid,
    output srf_pkg::t_out o_res
);

    localparam int POS_W = $clog2(MAX_FRAME);

    logic [POS_W-1:0]                    r_pos, n_pos;
    logic                                r_in_run, n_in_run;
    logic [POS_W-1:0]                    r_start, n_start;
    logic [POS_W-1:0]                    r_last_sat, n_last_sat;
    logic [srf_pkg::GAP_W-1:0]           r_below, n_below;
    logic signed [srf_pkg::SAMPLE_W-1:0] r_peak, n_peak;

    logic                        sat;
    logic [srf_pkg::GAP_W-1:0]   gap;
    logic [srf_pkg::GAP_W-1:0]   below_inc;
    logic [srf_pkg::IDX_W-1:0]   pos_ext;
    logic                        can_start;
    logic                        gap_close;

    assign sat       = i_item.sample >= i_cfg.sat_threshold;
    assign gap       = (i_cfg.gap_length == '0) ? srf_pkg::GAP_W'(1) : i_cfg.gap_length;
    assign below_inc = (r_below == '1) ? r_below : r_below + 1'b1;
    assign pos_ext   = srf_pkg::IDX_W'(r_pos);
    assign can_start = sat && (pos_ext != '0) && (pos_ext < i_cfg.start_limit);
    assign gap_close = r_in_run && !sat && (below_inc >= gap);

    always_comb begin
        n_in_run   = r_in_run;
        n_start    = r_start;
        n_last_sat = r_last_sat;
        n_below    = r_below;
        n_peak     = r_peak;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (r_in_run) begin
            if (sat) begin
                n_below    = '0;
                n_last_sat = r_pos;
                if (i_item.sample > r_peak) begin
                    n_peak = i_item.sample;
                end
            end else if (gap_close) begin
                n_in_run = 1'b0;
                n_below  = '0;
            end else begin
                n_below = below_inc;
            end
        end else if (can_start) begin
            n_in_run   = 1'b1;
            n_start    = r_pos;
            n_last_sat = r_pos;
            n_below    = '0;
            n_peak     = i_item.sample;
        end

        // A closing gap wins; otherwise an open run is cut at the frame's end.
        if (gap_close) begin
            o_res_valid     = 1'b1;
            o_res.run_start = srf_pkg::IDX_W'(r_start);
            o_res.run_end   = srf_pkg::IDX_W'(r_last_sat);
            o_res.peak      = r_peak;
        end else if (i_item.frame_end && n_in_run) begin
            o_res_valid     = 1'b1;
            o_res.run_start = srf_pkg::IDX_W'(n_start);
            o_res.run_end   = pos_ext;
            o_res.peak      = n_peak;
        end

        if (i_item.frame_end) begin
            n_in_run = 1'b0;
            n_below  = '0;
            n_pos    = '0;
        end else if (r_pos == POS_W'(MAX_FRAME - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_in_run   <= 1'b0;
            r_start    <= '0;
            r_last_sat <= '0;
            r_below    <= '0;
            r_peak     <= '0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_in_run   <= n_in_run;
            r_start    <= n_start;
            r_last_sat <= n_last_sat;
            r_below    <= n_below;
            r_peak     <= n_peak;
        end
    end

endmodule

// File: hdl/saturation_run_flattener_unit.sv
// Top level of the saturation run flattener: input register, run tracking
// core and result register. Depends on srf_pkg, srf_regs and srf_core.
//
// Samples of one trace enter in order, one request per cycle, and each
// sample is processed once it sits in the input register, in a single pass
// on to the result register; a closed run of saturated
// samples appears as one result request with its start index, end index and
// peak. The block sustains one sample per clock: the input side keeps
// accepting while a result waits, and stalls only when the result register
// is full, not taken, and the sample in the input register closes a run.
// Indices count modulo MAX_FRAME and restart at zero after a sample marked
// as frame end. Configuration registers sit at byte addresses 0
// (threshold), 4 (gap length) and 8 (start limit) and are meant to be
// written while no samples are in flight.
module saturation_run_flattener_unit #(
    parameter int MAX_FRAME = srf_pkg::MAX_FRAME_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  srf_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output srf_pkg::t_out                   o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [srf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [srf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    srf_pkg::t_cfg cfg;
    logic          r_in_valid;
    srf_pkg::t_in  r_in_data;
    logic          r_out_valid;
    srf_pkg::t_out r_out_data;
    logic          advance;
    logic          res_valid;
    srf_pkg::t_out res;

    srf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    srf_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in_data),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The held sample moves on unless its result would overwrite a waiting one.
    assign advance     = r_in_valid && (!res_valid || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_data <= res;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |-> o_in_ready)
        else $error("input stalled while result is taken");

endmodule

// File: tb/saturation_run_flattener_unit_tb.sv
// Self-checking testbench for saturation_run_flattener_unit: directed trace
// table and random traces under several register settings.
// Depends on srf_pkg and the block's RTL only.
module saturation_run_flattener_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srf_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [3:0]  UNMAPPED_ADDR = 4'd12;
    localparam logic signed [31:0] S_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN  = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_RUN   = 2'd2
    } row_chk_e;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               frame_end;
        row_chk_e           chk;
        t_out               run;
    } dir_row_t;

    typedef struct packed {
        logic signed [31:0] threshold;
        logic               rand_thr;
        logic [15:0]        gap;
        logic [15:0]        limit;
        logic [7:0]         send_idle;
        logic [7:0]         stall;
        logic [15:0]        items;
    } phase_t;

    // Directed trace under the reset settings: threshold at the maximum, gap 4.
    localparam dir_row_t DIR_ROWS [0:19] = '{
        '{S_MAX,            1'b0, CHK_NONE, '0},  // index 0 never starts a run
        '{S_MIN,            1'b0, CHK_NONE, '0},
        '{S_MAX,            1'b0, CHK_NONE, '0},
        '{32'sh0,           1'b0, CHK_NONE, '0},
        '{S_MAX,            1'b0, CHK_NONE, '0},
        '{-32'sd1,          1'b0, CHK_NONE, '0},
        '{32'sh7FFF_FFFE,   1'b0, CHK_NONE, '0},
        '{S_MIN,            1'b0, CHK_NONE, '0},
        '{32'sh0,           1'b0, CHK_RUN,  '{16'd2, 16'd4, S_MAX}},
        '{S_MAX,            1'b1, CHK_RUN,  '{16'd9, 16'd9, S_MAX}},
        '{32'sh0,           1'b1, CHK_NONE, '0},
        '{32'sh0,           1'b0, CHK_NONE, '0},
        '{S_MAX,            1'b0, CHK_NONE, '0},
        '{32'sd5,           1'b1, CHK_RUN,  '{16'd1, 16'd2, S_MAX}},
        '{32'sd1,           1'b0, CHK_NONE, '0},
        '{S_MAX,            1'b0, CHK_NONE, '0},
        '{-32'sd2,          1'b0, CHK_NONE, '0},
        '{32'sh5555_5555,   1'b0, CHK_NONE, '0},
        '{32'shAAAA_AAAA,   1'b0, CHK_NONE, '0},
        '{32'sh0,           1'b1, CHK_RUN,  '{16'd1, 16'd1, S_MAX}}
    };

    localparam phase_t PHASES [0:7] = '{
        '{32'sd0,      1'b0, 16'd3,     16'd65535, 8'd0,  8'd0,  16'd300},
        '{S_MIN,       1'b0, 16'd1,     16'd10,    8'd59, 8'd0,  16'd300},
        '{S_MAX,       1'b0, 16'd65535, 16'd65535, 8'd0,  8'd59, 16'd250},
        '{32'sd100,    1'b0, 16'd0,     16'd0,     8'd12, 8'd12, 16'd100},
        '{-32'sd5,     1'b0, 16'd2,     16'd1,     8'd0,  8'd0,  16'd100},
        '{32'sd12345,  1'b0, 16'd5,     16'd20,    8'd59, 8'd0,  16'd300},
        '{32'sd0,      1'b1, 16'd6,     16'd65535, 8'd0,  8'd59, 16'd300},
        '{32'sd0,      1'b0, 16'd4,     16'd30000, 8'd12, 8'd12, 16'd300}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr  = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;

    // Side channel that travels with each sample request.
    row_chk_e    row_chk = CHK_MODEL;
    t_out        row_run = '0;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    t_out        runs_pending[$];

    // Predictor copy of the registers and the run tracking state.
    t_cfg        cfg;
    logic [15:0] pos_q;
    logic        open_q;
    logic [15:0] start_q;
    logic [15:0] last_sat_q;
    logic [15:0] below_q;
    logic signed [31:0] peak_q;

    saturation_run_flattener_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Advances the run tracker by one sample; returns 1 when a run closes.
    function automatic bit flatten_step(input t_in d, output t_out run);
        logic signed [31:0] x;
        logic [15:0] pos;
        int  gap;
        bit  sat;
        bit  closed;
        x      = d.sample;
        pos    = pos_q;
        gap    = (cfg.gap_length == 0) ? 1 : int'(cfg.gap_length);
        sat    = ($signed(x) >= $signed(cfg.sat_threshold));
        closed = 1'b0;
        run    = '0;
        if (open_q) begin
            if (sat) begin
                below_q    = '0;
                last_sat_q = pos;
                if ($signed(x) > $signed(peak_q))
                    peak_q = x;
            end else begin
                if (below_q != 16'hFFFF)
                    below_q = below_q + 16'd1;
                if (int'(below_q) >= gap) begin
                    run    = '{start_q, last_sat_q, peak_q};
                    closed = 1'b1;
                    open_q = 1'b0;
                    below_q = '0;
                end
            end
        end else if (sat && pos >= 16'd1 && pos < cfg.start_limit) begin
            open_q     = 1'b1;
            start_q    = pos;
            last_sat_q = pos;
            below_q    = '0;
            peak_q     = x;
        end
        if (d.frame_end) begin
            // A run still open at the end of the trace closes on this sample.
            if (open_q && !closed) begin
                run    = '{start_q, pos, peak_q};
                closed = 1'b1;
            end
            open_q  = 1'b0;
            below_q = '0;
            pos_q   = '0;
        end else begin
            pos_q = pos + 16'd1;
        end
        return closed;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        t_out run;
        bit   got_run;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (runs_pending.size() == 0) begin
                    report_mismatch("unexpected run", 64'(o_out_data), 64'd0);
                end else begin
                    want = runs_pending.pop_front();
                    if (o_out_data.run_start != want.run_start)
                        report_mismatch("run_start", 64'(o_out_data.run_start),
                                        64'(want.run_start));
                    if (o_out_data.run_end != want.run_end)
                        report_mismatch("run_end", 64'(o_out_data.run_end),
                                        64'(want.run_end));
                    if (o_out_data.peak != want.peak)
                        report_mismatch("peak", 64'(o_out_data.peak), 64'(want.peak));
                end
            end
            if (i_in_valid && o_in_ready) begin
                got_run = flatten_step(i_in_data, run);
                case (row_chk)
                    CHK_MODEL: begin
                        if (got_run)
                            runs_pending.push_back(run);
                    end
                    CHK_RUN: begin
                        runs_pending.push_back(row_run);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] data;
        data = value;
        // The narrow registers must ignore the upper data bits.
        if (idx != REG_SAT_THRESHOLD)
            data[31:16] = $urandom_range(1) ? 16'($urandom) : 16'd0;
        apb_write({idx, 2'b00}, data);
        case (idx)
            REG_SAT_THRESHOLD: cfg.sat_threshold = value;
            REG_GAP_LENGTH:    cfg.gap_length    = value[15:0];
            REG_START_LIMIT:   cfg.start_limit   = value[15:0];
            default: begin
            end
        endcase
    endtask

    task automatic read_check(input t_reg_idx idx);
        logic [31:0] want;
        logic [31:0] got;
        case (idx)
            REG_SAT_THRESHOLD: want = cfg.sat_threshold;
            REG_GAP_LENGTH:    want = {16'd0, cfg.gap_length};
            default:           want = {16'd0, cfg.start_limit};
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got != want)
            report_mismatch("register readback", 64'(got), 64'(want));
    endtask

    task automatic read_all();
        read_check(REG_SAT_THRESHOLD);
        read_check(REG_GAP_LENGTH);
        read_check(REG_START_LIMIT);
    endtask

    task automatic send_sample(input logic signed [31:0] sample, input logic frame_end,
                               input row_chk_e chk, input t_out run);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{sample: sample, frame_end: frame_end};
        row_chk    <= chk;
        row_run    <= run;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Waits until every expected run has arrived and the block has gone quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (runs_pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int rand_between(input longint lo, input longint hi);
        logic [62:0] r;
        r = 63'({$urandom, $urandom});
        return int'(lo + longint'(r % (hi - lo + 1)));
    endfunction

    function automatic int saturated_value();
        int pick;
        pick = $urandom_range(3);
        if (pick == 0)
            return cfg.sat_threshold;
        if (pick == 1)
            return S_MAX;
        return rand_between(longint'(cfg.sat_threshold), longint'(S_MAX));
    endfunction

    function automatic int quiet_value();
        int pick;
        pick = $urandom_range(3);
        if (cfg.sat_threshold == S_MIN)
            return S_MIN;
        if (pick == 0)
            return cfg.sat_threshold - 1;
        if (pick == 1)
            return S_MIN;
        return rand_between(longint'(S_MIN), longint'(cfg.sat_threshold) - 1);
    endfunction

    // Dips are at most 64 samples long; within that they stay short of the gap or just reach past it.
    function automatic int dip_length();
        int gap;
        gap = (cfg.gap_length == 0) ? 1 : int'(cfg.gap_length);
        if ($urandom_range(1))
            return (gap > 1) ? $urandom_range(1, (gap > 64) ? 64 : gap - 1) : 1;
        return (gap > 60) ? 64 : $urandom_range(gap, gap + 3);
    endfunction

    // One trace of alternating saturated bursts and dips, with some noise.
    task automatic send_frame(input int len);
        int   seg_left;
        bit   seg_sat;
        logic signed [31:0] x;
        seg_sat  = 1'b0;
        seg_left = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
            if (seg_left == 0) begin
                seg_sat  = !seg_sat;
                seg_left = seg_sat ? $urandom_range(1, 6) : dip_length();
            end
            if ($urandom_range(9) == 0)
                x = $urandom;
            else
                x = seg_sat ? saturated_value() : quiet_value();
            seg_left--;
            send_sample(x, i == len - 1, CHK_MODEL, '0);
        end
    endtask

    initial begin
        int items_left;
        int len;
        bit paused;
        cfg        = '{SAT_THRESHOLD_RST, GAP_LENGTH_RST, START_LIMIT_RST};
        pos_q      = '0;
        open_q     = 1'b0;
        start_q    = '0;
        last_sat_q = '0;
        below_q    = '0;
        peak_q     = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_all();

        foreach (DIR_ROWS[i])
            send_sample(DIR_ROWS[i].sample, DIR_ROWS[i].frame_end, DIR_ROWS[i].chk,
                        DIR_ROWS[i].run);
        settle();

        // A write to an address with no register behind it changes nothing.
        apb_write(UNMAPPED_ADDR, $urandom);

        foreach (PHASES[p]) begin
            write_reg(REG_SAT_THRESHOLD,
                      PHASES[p].rand_thr ? $urandom : PHASES[p].threshold);
            write_reg(REG_GAP_LENGTH, {16'd0, PHASES[p].gap});
            write_reg(REG_START_LIMIT, {16'd0, PHASES[p].limit});
            read_all();
            send_idle_pct = PHASES[p].send_idle;
            stall_pct     = PHASES[p].stall;
            items_left    = PHASES[p].items;
            paused        = 1'b0;
            while (items_left > 0) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(41, 150)
                                               : $urandom_range(1, 40);
                if (len > items_left)
                    len = items_left;
                send_frame(len);
                items_left -= len;
                if (!paused && items_left < PHASES[p].items / 2) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (runs_pending.size() != 0)
                        @(posedge i_clk);
                    paused = 1'b1;
                end
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
